FILE: design/bfd_pkg.sv
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types and constants of the double-hashing bloom filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bfd_pkg;

   // Operation codes carried with every item.
   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Configuration register indexes.
   localparam logic CSR_BITS_IN_USE = 1'b0;
   localparam logic CSR_HASH_COUNT  = 1'b1;

   localparam int BITS_W  = 17;
   localparam int HCNT_W  = 5;
   localparam logic [BITS_W-1:0] BITS_RESET = 17'd65536;
   localparam logic [HCNT_W-1:0] HCNT_RESET = 5'd7;

   // Hash constants. The FNV prime is 2^40 + 0x1B3.
   localparam logic [63:0] FNV_BASIS     = 64'd14695981039346656037;
   localparam logic [8:0]  FNV_PRIME_LO  = 9'h1B3;
   localparam int          FNV_PRIME_SH  = 40;
   localparam logic [63:0] DJB_SEED      = 64'd5381;
   localparam int          DJB_SHIFT     = 5;

   // Remainder unit: dividend bits retired per cycle.
   localparam int HASH_W     = 64;
   localparam int DIGIT_BITS = 4;
   localparam int MOD_STEPS  = HASH_W / DIGIT_BITS;

   // Command passed from the front to the back.
   typedef struct packed {
      op_type      op;
      logic [63:0] h1;
      logic [63:0] h2;
   } cmd_type;

endpackage

`default_nettype wire

FILE: design/bfd_front.sv
// ----------------------------------------------------------------------------
// bfd_front
// Accepts key bytes, folds them into the FNV-1a and DJB2 hashes, and queues
// one command for each finished operation.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire  [7:0]            key_byte,
   input  wire                   has_byte,
   input  wire  [1:0]            opcode,
   input  wire                   last_byte,
   input  wire                   init_done,
   input  wire                   q_full,
   output logic                  q_push,
   output bfd_pkg::cmd_type      q_cmd
);

   logic [63:0] fnv_ff, fnv_in;
   logic [63:0] djb_ff, djb_in;
   logic [63:0] ext;
   logic [63:0] fnv_x;
   logic        accept;
   bfd_pkg::op_type op;

   assign op         = bfd_pkg::op_type'(opcode);
   assign req_tready = init_done && !q_full;
   assign accept     = req_tvalid && req_tready;

   // Sign-extended byte and the next hash values.
   always_comb begin
      ext    = {{56{key_byte[7]}}, key_byte};
      fnv_x  = fnv_ff ^ ext;
      fnv_in = fnv_ff;
      djb_in = djb_ff;
      if (has_byte) begin
         fnv_in = (fnv_x << bfd_pkg::FNV_PRIME_SH) + (fnv_x * 64'(bfd_pkg::FNV_PRIME_LO));
         djb_in = (djb_ff << bfd_pkg::DJB_SHIFT) + djb_ff + ext;
      end
   end

   // A command is queued for the last item of add, query or clear.
   always_comb begin
      q_push   = accept && last_byte && (op != bfd_pkg::OP_NONE);
      q_cmd.op = op;
      q_cmd.h1 = fnv_in;
      q_cmd.h2 = djb_in;
   end

   // Hash accumulators restart after every finished operation.
   always_ff @(posedge clock) begin
      if (reset) begin
         fnv_ff <= bfd_pkg::FNV_BASIS;
         djb_ff <= bfd_pkg::DJB_SEED;
      end else if (accept) begin
         if (op == bfd_pkg::OP_CLEAR || op == bfd_pkg::OP_NONE) begin
            if (op == bfd_pkg::OP_CLEAR && last_byte) begin
               fnv_ff <= bfd_pkg::FNV_BASIS;
               djb_ff <= bfd_pkg::DJB_SEED;
            end
         end else if (last_byte) begin
            fnv_ff <= bfd_pkg::FNV_BASIS;
            djb_ff <= bfd_pkg::DJB_SEED;
         end else begin
            fnv_ff <= fnv_in;
            djb_ff <= djb_in;
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/bfd_fifo.sv
// ----------------------------------------------------------------------------
// bfd_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_fifo (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  bfd_pkg::cmd_type   push_cmd,
   input  wire                pop,
   output bfd_pkg::cmd_type   head_cmd,
   output logic               full,
   output logic               empty
);

   bfd_pkg::cmd_type slot_ff [2];
   logic             wr_ff;
   logic             rd_ff;
   logic [1:0]       count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign head_cmd = slot_ff[rd_ff];

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/bfd_mod.sv
// ----------------------------------------------------------------------------
// bfd_mod
// Digit-serial remainder of a 64-bit hash by the filter modulus.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_mod #(
   parameter int M_W = 17
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   input  wire  [63:0]      dividend,
   input  wire  [M_W-1:0]   modulus,
   output logic [M_W-1:0]   remainder,
   output logic             done
);

   localparam int CNT_W = $clog2(bfd_pkg::MOD_STEPS);

   logic [63:0]      dvd_ff;
   logic [M_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [M_W:0]     trial;

   assign remainder = rem_ff;
   assign done      = done_ff;

   // Restoring steps for the next few dividend bits.
   always_comb begin
      rem_in = rem_ff;
      trial  = '0;
      for (int s = 0; s < bfd_pkg::DIGIT_BITS; s++) begin
         trial = {rem_in, dvd_ff[63-s]};
         if (trial >= {1'b0, modulus}) begin
            trial = trial - {1'b0, modulus};
         end
         rem_in = trial[M_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            dvd_ff  <= dividend;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            dvd_ff <= dvd_ff << bfd_pkg::DIGIT_BITS;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(bfd_pkg::MOD_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/bfd_back.sv
// ----------------------------------------------------------------------------
// bfd_back
// Executes queued commands: reduces each 64-bit probe value, walks the probes
// over the bit array, sweeps the array on clear, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_back #(
   parameter int ARRAY_BITS = 65536,
   parameter int MAX_HASHES = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire  [$clog2(ARRAY_BITS+1)-1:0]      modulus,
   input  wire  [$clog2(MAX_HASHES)+1-1:0]      probes,
   input  wire                                  q_empty,
   input  bfd_pkg::cmd_type                     q_cmd,
   output logic                                 q_pop,
   output logic                                 init_done,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic                                 maybe_present,
   output logic [1:0]                           done_opcode,
   output logic [31:0]                          element_count
);

   localparam int M_W    = $clog2(ARRAY_BITS + 1);
   localparam int K_W    = $clog2(MAX_HASHES) + 1;
   localparam int ROWS   = (ARRAY_BITS + 7) / 8;
   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_CLEAR, S_MOD, S_RD, S_CHK, S_DONE
   } state_type;

   state_type        state_ff;
   bfd_pkg::op_type  op_ff;
   logic [ROW_AW-1:0] addr_ff;
   logic [ROW_AW-1:0] row_ff;
   logic [2:0]       bitsel_ff;
   logic [M_W-1:0]   pr_ff;
   logic [63:0]      ph_ff;
   logic [63:0]      h2_ff;
   logic [K_W-1:0]   idx_ff;
   logic             all_ff;
   logic [31:0]      cnt_ff;
   logic             init_done_ff;
   logic             rsp_valid_ff;
   logic             rsp_present_ff;
   logic [1:0]       rsp_op_ff;
   logic [31:0]      rsp_cnt_ff;

   logic [7:0]       mem [ROWS];
   logic [7:0]       rd_row_ff;
   logic [ROW_AW-1:0] rd_addr;
   logic             mem_we;
   logic [ROW_AW-1:0] mem_wa;
   logic [7:0]       mem_wd;

   logic             mod_start;
   logic [63:0]      mod_dvd;
   logic [63:0]      ph_next;
   logic             last_probe;
   logic [M_W-1:0]   r1;
   logic             mod_done;
   logic [31:0]      cnt_next;

   assign init_done     = init_done_ff;
   assign rsp_tvalid    = rsp_valid_ff;
   assign maybe_present = rsp_present_ff;
   assign done_opcode   = rsp_op_ff;
   assign element_count = rsp_cnt_ff;

   assign q_pop      = (state_ff == S_IDLE) && !q_empty;
   assign last_probe = (idx_ff == probes - 1'b1);
   assign ph_next    = ph_ff + h2_ff;

   // The first probe is h1 itself; each later one adds h2 modulo 2^64.
   assign mod_start = (q_pop && (q_cmd.op != bfd_pkg::OP_CLEAR)) ||
                      ((state_ff == S_CHK) && !last_probe);
   assign mod_dvd   = (state_ff == S_IDLE) ? q_cmd.h1 : ph_next;

   // One remainder unit reduces each full 64-bit probe value in turn.
   bfd_mod #(.M_W(M_W)) u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(mod_dvd),
      .modulus(modulus), .remainder(r1), .done(mod_done)
   );

   // Saturating element count after the current operation.
   always_comb begin
      cnt_next = cnt_ff;
      if (op_ff == bfd_pkg::OP_ADD && cnt_ff != 32'hFFFF_FFFF) begin
         cnt_next = cnt_ff + 32'd1;
      end
   end

   // Bit array port control.
   always_comb begin
      rd_addr = ROW_AW'(pr_ff >> 3);
      mem_we  = 1'b0;
      mem_wa  = row_ff;
      mem_wd  = rd_row_ff | (8'b1 << bitsel_ff);
      if (state_ff == S_INIT || state_ff == S_CLEAR) begin
         mem_we = 1'b1;
         mem_wa = addr_ff;
         mem_wd = '0;
      end else if (state_ff == S_CHK && op_ff == bfd_pkg::OP_ADD) begin
         mem_we = 1'b1;
      end
   end

   // Bit array, eight bits to a row.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_row_ff <= mem[rd_addr];
   end

   // Sequencer with the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         addr_ff      <= '0;
         init_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         op_ff        <= bfd_pkg::OP_ADD;
         idx_ff       <= '0;
         all_ff       <= 1'b1;
      end else begin
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_INIT: begin
               addr_ff <= addr_ff + 1'b1;
               if (addr_ff == ROW_AW'(ROWS - 1)) begin
                  init_done_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (q_pop) begin
                  op_ff <= q_cmd.op;
                  if (q_cmd.op == bfd_pkg::OP_CLEAR) begin
                     addr_ff  <= '0;
                     state_ff <= S_CLEAR;
                  end else begin
                     ph_ff    <= q_cmd.h1;
                     h2_ff    <= q_cmd.h2;
                     idx_ff   <= '0;
                     all_ff   <= 1'b1;
                     state_ff <= S_MOD;
                  end
               end
            end
            S_CLEAR: begin
               addr_ff <= addr_ff + 1'b1;
               if (addr_ff == ROW_AW'(ROWS - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_DONE;
               end
            end
            S_MOD: begin
               if (mod_done) begin
                  pr_ff    <= r1;
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               row_ff    <= rd_addr;
               bitsel_ff <= pr_ff[2:0];
               state_ff  <= S_CHK;
            end
            S_CHK: begin
               if (op_ff == bfd_pkg::OP_QUERY && !rd_row_ff[bitsel_ff]) begin
                  all_ff <= 1'b0;
               end
               idx_ff <= idx_ff + 1'b1;
               if (last_probe) begin
                  state_ff <= S_DONE;
               end else begin
                  ph_ff    <= ph_next;
                  state_ff <= S_MOD;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_op_ff      <= op_ff;
                  rsp_present_ff <= (op_ff == bfd_pkg::OP_QUERY) && all_ff;
                  rsp_cnt_ff     <= cnt_next;
                  cnt_ff         <= cnt_next;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: design/bloom_filter_fnv_djb2.sv
// ----------------------------------------------------------------------------
// bloom_filter_fnv_djb2
// Bloom filter with FNV-1a and DJB2 double hashing over a streamed key.
// ----------------------------------------------------------------------------
// Key bytes arrive on the req stream, one item per cycle while req_tready
// is high, tagged in tuser with add, query or clear; tlast ends a key. Each
// add, query or finished clear returns one item on the rsp stream with the
// opcode, the query hit and the element count.
// A key byte is hashed as it is accepted. The last item of a key queues a
// command for the back end, which forms each 64-bit probe value h1 + i*h2,
// reduces it with a 4-bit-per-cycle remainder unit, then reads one row of
// the bit array in S_RD and checks or writes it in S_CHK. The command is
// taken in S_IDLE and the result is issued from S_DONE. A clear sweeps the
// array one 8-bit row per cycle.
// After reset the same sweep clears the array, and req_tready stays low until
// it ends; configuration writes are taken always.
// A stalled rsp stream holds its result; the two-entry command queue lets
// the front keep taking key bytes until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_filter_fnv_djb2 #(
   parameter int ARRAY_BITS = 65536,
   parameter int MAX_HASHES = 16
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [15:0]  req_tdata,   // key_byte[7:0], has_byte[8], zero pad
   input  wire  [1:0]   req_tuser,   // opcode[1:0]
   input  wire          req_tlast,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [39:0]  rsp_tdata,   // maybe_present[0], element_count[32:1], pad
   output logic [1:0]   rsp_tuser,   // done_opcode[1:0]
   input  wire          csr_we,
   input  wire  [0:0]   csr_addr,
   input  wire  [16:0]  csr_wdata
);

   localparam int M_W = $clog2(ARRAY_BITS + 1);
   localparam int K_W = $clog2(MAX_HASHES) + 1;

   logic [bfd_pkg::BITS_W-1:0] bits_ff;
   logic [bfd_pkg::HCNT_W-1:0] hcnt_ff;
   logic [M_W-1:0]             modulus;
   logic [K_W-1:0]             probes;

   bfd_pkg::cmd_type push_cmd, head_cmd;
   logic push, pop, full, empty, init_done;
   logic present;
   logic [1:0] done_op;
   logic [31:0] count;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= bfd_pkg::BITS_RESET;
         hcnt_ff <= bfd_pkg::HCNT_RESET;
      end else if (csr_we) begin
         if (csr_addr[0] == bfd_pkg::CSR_BITS_IN_USE) begin
            bits_ff <= csr_wdata[bfd_pkg::BITS_W-1:0];
         end else begin
            hcnt_ff <= csr_wdata[bfd_pkg::HCNT_W-1:0];
         end
      end
   end

   // Effective modulus and probe count, clamped to the array and probe limits.
   always_comb begin
      if (bits_ff == '0) begin
         modulus = M_W'(1);
      end else if (32'(bits_ff) > 32'(ARRAY_BITS)) begin
         modulus = M_W'(ARRAY_BITS);
      end else begin
         modulus = M_W'(bits_ff);
      end
      if (hcnt_ff == '0) begin
         probes = K_W'(1);
      end else if (32'(hcnt_ff) > 32'(MAX_HASHES)) begin
         probes = K_W'(MAX_HASHES);
      end else begin
         probes = K_W'(hcnt_ff);
      end
   end

   bfd_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .key_byte(req_tdata[7:0]), .has_byte(req_tdata[8]),
      .opcode(req_tuser), .last_byte(req_tlast),
      .init_done(init_done), .q_full(full), .q_push(push), .q_cmd(push_cmd)
   );

   bfd_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_cmd(push_cmd),
      .pop(pop), .head_cmd(head_cmd), .full(full), .empty(empty)
   );

   bfd_back #(.ARRAY_BITS(ARRAY_BITS), .MAX_HASHES(MAX_HASHES)) u_back (
      .clock(clock), .reset(reset), .modulus(modulus), .probes(probes),
      .q_empty(empty), .q_cmd(head_cmd), .q_pop(pop), .init_done(init_done),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .maybe_present(present), .done_opcode(done_op), .element_count(count)
   );

   assign rsp_tdata = {7'd0, count, present};
   assign rsp_tuser = done_op;

endmodule

`default_nettype wire
